[hw/rtl/tsr_pkg.sv]
// Shared types, register indexes and constants of the trapezoid span rasteriser.
// Used by every module in hw/rtl; it depends on nothing else.
`default_nettype none

package tsr_pkg;

    // Build-time limits of the block.
    localparam int unsigned MAX_ROWS       = 64;
    localparam int unsigned BITS_PER_PIXEL = 16;
    localparam int unsigned ROWS_W         = $clog2(MAX_ROWS + 1);

    // Colour bits that are kept on every span.
    localparam logic [31:0] COLOR_MASK = 32'((64'd1 << BITS_PER_PIXEL) - 64'd1);

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 2'd2;

    // Register reset values and the widest screen that clipping honours.
    localparam logic [12:0] SCREEN_WIDTH_RST = 13'd320;
    localparam logic [31:0] FRAME_BASE_RST   = 32'd0;
    localparam logic [14:0] LINE_STRIDE_RST  = 15'd320;
    localparam logic [12:0] MAX_CLIP_WIDTH   = 13'd4096;

    // The slope divider retires one quotient bit per cycle over a 33-bit dividend.
    localparam int unsigned DIV_STEPS = 33;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef struct packed {
        logic [11:0]        top_row;
        logic [11:0]        bottom_row;
        logic signed [31:0] top_left_x;
        logic signed [31:0] top_right_x;
        logic signed [31:0] bottom_left_x;
        logic signed [31:0] bottom_right_x;
        logic [31:0]        fill_color;
    } in_item_t;

    typedef struct packed {
        logic [11:0] span_row;
        logic [11:0] span_start;
        logic [11:0] span_end;
        logic [31:0] span_address;
        logic [31:0] span_color;
        logic        span_drawn;
        logic        span_last;
        logic        rows_truncated;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic prep;
        logic addr;
        logic slopes;
        logic emit_row;
        logic emit_empty;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic div_done;
        logic out_free;
        logic last_row;
    } ctrl_status_t;

endpackage

`default_nettype wire

[hw/rtl/tsr_div.sv]
// Serial signed divider: 33-bit dividend by a 13-bit positive divisor, truncating.
// One quotient bit per cycle; depends on tsr_pkg.
`default_nettype none

module tsr_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [32:0] dividend,
    input  wire logic [12:0]        divisor,
    output logic                    busy,
    output logic [31:0]             quotient
);

    logic [32:0]                   mag_reg,  mag_next;
    logic [12:0]                   rem_reg,  rem_next;
    logic [12:0]                   dvs_reg,  dvs_next;
    logic                          neg_reg,  neg_next;
    logic                          busy_reg, busy_next;
    logic [tsr_pkg::DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [13:0]                   rem_shift;
    logic                          q_bit;

    // Restoring division on the magnitude; the sign is put back at the end.
    always_comb begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_shift = {rem_reg, mag_reg[32]};
        q_bit     = rem_shift >= {1'b0, dvs_reg};
        if (start) begin
            mag_next  = dividend[32] ? 33'(-dividend) : 33'(dividend);
            rem_next  = '0;
            dvs_next  = divisor;
            neg_next  = dividend[32];
            busy_next = 1'b1;
            cnt_next  = tsr_pkg::DIV_CNT_W'(tsr_pkg::DIV_STEPS);
        end else if (busy_reg) begin
            rem_next = q_bit ? 13'(rem_shift - {1'b0, dvs_reg}) : rem_shift[12:0];
            mag_next = {mag_reg[31:0], q_bit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == tsr_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign quotient = neg_reg ? 32'(-mag_reg[31:0]) : mag_reg[31:0];

endmodule

`default_nettype wire

[hw/rtl/tsr_ctrl.sv]
// Controller of the trapezoid span rasteriser: sequences load, slope division and rows.
// Depends on tsr_pkg for the command and status structs.
`default_nettype none

module tsr_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire tsr_pkg::ctrl_status_t status,
    output tsr_pkg::ctrl_cmd_t         cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_ROWS  = 3'd4;
    localparam logic [2:0] S_EMPTY = 3'd5;

    logic [2:0] state_reg, state_next;

    // Next state and the commands of each state.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_ADDR;
            end
            S_ADDR: begin
                cmd.addr   = 1'b1;
                state_next = status.empty ? S_EMPTY : S_DIV;
            end
            S_DIV: begin
                if (status.div_done) begin
                    cmd.slopes = 1'b1;
                    state_next = S_ROWS;
                end
            end
            S_ROWS: begin
                if (status.out_free) begin
                    cmd.emit_row = 1'b1;
                    if (status.last_row) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_EMPTY: begin
                if (status.out_free) begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tsr_datapath.sv]
// Datapath of the trapezoid span rasteriser: registers, edge walker, clipping and output.
// Depends on tsr_pkg and instantiates two tsr_div slope dividers.
`default_nettype none

module tsr_datapath (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [tsr_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [31:0]                           cfg_wdata,
    input  wire tsr_pkg::in_item_t                     s_item,
    input  wire tsr_pkg::ctrl_cmd_t                    cmd,
    output tsr_pkg::ctrl_status_t                      status,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output tsr_pkg::out_item_t                         m_item
);

    // Configuration registers.
    logic [12:0] screen_width_reg;
    logic [31:0] frame_base_reg;
    logic [14:0] line_stride_reg;

    // Per-trapezoid state.
    logic signed [31:0]          left_edge_reg,  left_edge_next;
    logic signed [31:0]          right_edge_reg, right_edge_next;
    logic [31:0]                 left_slope_reg, left_slope_next;
    logic [31:0]                 right_slope_reg, right_slope_next;
    logic [tsr_pkg::ROWS_W-1:0]  rows_left_reg,  rows_left_next;
    logic [11:0]                 current_row_reg, current_row_next;
    logic [31:0]                 row_address_reg, row_address_next;
    logic [26:0]                 prod_reg;
    logic signed [32:0]          diff_l_reg, diff_r_reg;
    logic [12:0]                 nrows_reg;
    logic                        empty_reg, trunc_reg;
    logic [31:0]                 color_reg;

    // Output register.
    logic                        m_valid_reg;
    tsr_pkg::out_item_t          out_reg, out_next;

    logic [12:0]        nrows_in;
    logic               empty_in;
    logic               busy_l, busy_r;
    logic [31:0]        quot_l, quot_r;
    logic               swap;
    logic signed [31:0] sw_l_edge, sw_r_edge;
    logic [31:0]        sw_l_slope, sw_r_slope;
    logic signed [15:0] ix1, ix2;
    logic [12:0]        width_c;
    logic signed [13:0] clip;
    logic signed [15:0] clip16;
    logic               drawn;
    logic [11:0]        span_s, span_e;
    logic [31:0]        span_off;

    // Row count of the incoming item; an inverted trapezoid is empty.
    assign empty_in = s_item.bottom_row < s_item.top_row;
    assign nrows_in = 13'(s_item.bottom_row) - 13'(s_item.top_row) + 13'd1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_width_reg <= tsr_pkg::SCREEN_WIDTH_RST;
            frame_base_reg   <= tsr_pkg::FRAME_BASE_RST;
            line_stride_reg  <= tsr_pkg::LINE_STRIDE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                tsr_pkg::REG_SCREEN_WIDTH: screen_width_reg <= cfg_wdata[12:0];
                tsr_pkg::REG_FRAME_BASE:   frame_base_reg   <= cfg_wdata;
                tsr_pkg::REG_LINE_STRIDE:  line_stride_reg  <= cfg_wdata[14:0];
                default: begin
                end
            endcase
        end
    end

    // Two slope dividers run side by side.
    tsr_div u_div_left (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.prep && !empty_reg),
        .dividend (diff_l_reg),
        .divisor  (nrows_reg),
        .busy     (busy_l),
        .quotient (quot_l)
    );

    tsr_div u_div_right (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.prep && !empty_reg),
        .dividend (diff_r_reg),
        .divisor  (nrows_reg),
        .busy     (busy_r),
        .quotient (quot_r)
    );

    // Span of the current row: swap crossed edges, floor, clip and address.
    always_comb begin
        swap       = left_edge_reg > right_edge_reg;
        sw_l_edge  = swap ? right_edge_reg  : left_edge_reg;
        sw_r_edge  = swap ? left_edge_reg   : right_edge_reg;
        sw_l_slope = swap ? right_slope_reg : left_slope_reg;
        sw_r_slope = swap ? left_slope_reg  : right_slope_reg;
        ix1        = 16'(sw_l_edge >>> 16);
        ix2        = 16'(sw_r_edge >>> 16);
        width_c    = (screen_width_reg > tsr_pkg::MAX_CLIP_WIDTH) ?
                     tsr_pkg::MAX_CLIP_WIDTH : screen_width_reg;
        clip       = $signed({1'b0, width_c}) - 14'sd1;
        clip16     = {{2{clip[13]}}, clip};
        drawn      = !clip[13] && !ix2[15] && (ix1 <= clip16);
        span_s     = '0;
        span_e     = '0;
        if (drawn) begin
            span_s = ix1[15] ? 12'd0 : ix1[11:0];
            span_e = (ix2 > clip16) ? clip16[11:0] : ix2[11:0];
        end
        span_off = 32'((20'(span_s) * 20'(tsr_pkg::BITS_PER_PIXEL)) >> 3);
    end

    // Next values of the walking state and the output register.
    always_comb begin
        left_edge_next   = left_edge_reg;
        right_edge_next  = right_edge_reg;
        left_slope_next  = left_slope_reg;
        right_slope_next = right_slope_reg;
        rows_left_next   = rows_left_reg;
        current_row_next = current_row_reg;
        row_address_next = row_address_reg;
        out_next         = out_reg;

        if (cmd.load) begin
            left_edge_next   = s_item.top_left_x;
            right_edge_next  = s_item.top_right_x;
            current_row_next = s_item.top_row;
            if (empty_in) begin
                rows_left_next = '0;
            end else if (nrows_in > 13'(tsr_pkg::MAX_ROWS)) begin
                rows_left_next = tsr_pkg::ROWS_W'(tsr_pkg::MAX_ROWS);
            end else begin
                rows_left_next = nrows_in[tsr_pkg::ROWS_W-1:0];
            end
        end

        if (cmd.addr) begin
            row_address_next = frame_base_reg + 32'(prod_reg);
        end

        if (cmd.slopes) begin
            left_slope_next  = quot_l;
            right_slope_next = quot_r;
        end

        if (cmd.emit_row) begin
            out_next.span_row       = current_row_reg;
            out_next.span_start     = span_s;
            out_next.span_end       = span_e;
            out_next.span_address   = row_address_reg + span_off;
            out_next.span_color     = color_reg;
            out_next.span_drawn     = drawn;
            out_next.span_last      = rows_left_reg == tsr_pkg::ROWS_W'(1);
            out_next.rows_truncated = trunc_reg;
            left_edge_next   = sw_l_edge + $signed(sw_l_slope);
            right_edge_next  = sw_r_edge + $signed(sw_r_slope);
            left_slope_next  = sw_l_slope;
            right_slope_next = sw_r_slope;
            rows_left_next   = rows_left_reg - 1'b1;
            current_row_next = current_row_reg + 12'd1;
            row_address_next = row_address_reg + 32'(line_stride_reg);
        end

        if (cmd.emit_empty) begin
            out_next.span_row       = current_row_reg;
            out_next.span_start     = '0;
            out_next.span_end       = '0;
            out_next.span_address   = row_address_reg;
            out_next.span_color     = color_reg;
            out_next.span_drawn     = 1'b0;
            out_next.span_last      = 1'b1;
            out_next.rows_truncated = 1'b0;
        end
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_edge_reg   <= '0;
            right_edge_reg  <= '0;
            left_slope_reg  <= '0;
            right_slope_reg <= '0;
            rows_left_reg   <= '0;
            current_row_reg <= '0;
            row_address_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            left_edge_reg   <= left_edge_next;
            right_edge_reg  <= right_edge_next;
            left_slope_reg  <= left_slope_next;
            right_slope_reg <= right_slope_next;
            rows_left_reg   <= rows_left_next;
            current_row_reg <= current_row_next;
            row_address_reg <= row_address_next;
            if (cmd.emit_row || cmd.emit_empty) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        out_reg <= out_next;
    end

    // Item capture and first-row address product; no reset needed.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            diff_l_reg <= 33'(s_item.bottom_left_x) - 33'(s_item.top_left_x);
            diff_r_reg <= 33'(s_item.bottom_right_x) - 33'(s_item.top_right_x);
            nrows_reg  <= nrows_in;
            empty_reg  <= empty_in;
            trunc_reg  <= !empty_in && (nrows_in > 13'(tsr_pkg::MAX_ROWS));
            color_reg  <= s_item.fill_color & tsr_pkg::COLOR_MASK;
        end
        if (cmd.prep) begin
            prod_reg <= 27'(current_row_reg) * 27'(line_stride_reg);
        end
    end

    assign status.empty    = empty_reg;
    assign status.div_done = !busy_l && !busy_r;
    assign status.out_free = !m_valid_reg || m_ready;
    assign status.last_row = rows_left_reg == tsr_pkg::ROWS_W'(1);
    assign m_valid         = m_valid_reg;
    assign m_item          = out_reg;

    // A result is never written over one that has not been taken.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_row || cmd.emit_empty) |-> (!m_valid_reg || m_ready))
        else $error("span written over a pending result");

    // Rows are only walked once both slopes are known.
    a_rows_after_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_row |-> (!busy_l && !busy_r))
        else $error("row emitted while a divider is busy");

    // The last row leaves no rows outstanding.
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit_row && status.last_row) |=> (rows_left_reg == '0))
        else $error("rows remain after the last span");

    // A visible span never runs backwards.
    a_span_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.span_drawn) |-> (out_reg.span_start <= out_reg.span_end))
        else $error("visible span has start beyond end");

endmodule

`default_nettype wire

[hw/rtl/trapezoid_span_rasterizer.sv]
// Top level of the trapezoid span rasteriser: joins the controller and the datapath.
// Depends on tsr_pkg, tsr_ctrl, tsr_datapath and tsr_div.
//
// Usage: one trapezoid item enters on the s_ channel (valid/ready). The block
// walks it row by row and returns one span item per row on the m_ channel,
// at most MAX_ROWS of them; span_last marks the final one. An inverted
// trapezoid (bottom above top) returns a single hidden span.
// Sequence: on acceptance the item is captured, then the two slope dividers
// are started and the first row address is set up. The dividers run in
// parallel and retire one quotient bit per cycle; the slopes are then loaded
// and spans leave at one per cycle while the receiver takes them. An inverted
// item skips the division. s_ready is high only between items; the next item
// may be accepted while the final span still waits in the output register.
// When the receiver holds m_ready low the walk stops with the pending span
// held steady and resumes where it left off. Reset (aresetn, synchronous,
// active low) empties the output, returns the controller to idle and loads
// the configuration registers with their defaults. Configuration is written
// through cfg_wr_en/cfg_index/cfg_wdata; the user must write it only while
// the block is idle, and the block itself does not enforce this.
`default_nettype none

module trapezoid_span_rasterizer (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire tsr_pkg::in_item_t             s_item,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output tsr_pkg::out_item_t                 m_item
);

    tsr_pkg::ctrl_cmd_t    cmd;
    tsr_pkg::ctrl_status_t status;

    // Sequencing.
    tsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Arithmetic, state and output register.
    tsr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_item    (s_item),
        .cmd       (cmd),
        .status    (status),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

`default_nettype wire

[dv/tsr_span_checker.sv]
// Span checker for the trapezoid span rasteriser: watches both channels and the
// register port, predicts every span and compares it with what the block returns.
// Depends on tsr_pkg for the item types, register indexes and build limits.
`default_nettype none

module tsr_span_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_wdata,
    input  wire logic                          s_valid,
    input  wire logic                          s_ready,
    input  wire tsr_pkg::in_item_t             s_item,
    input  wire logic                          m_valid,
    input  wire logic                          m_ready,
    input  wire tsr_pkg::out_item_t            m_item,
    output int                                 fail_count,
    output int                                 spans_pending
);

    // Shadow copy of the configuration registers.
    logic [12:0] cur_width;
    logic [31:0] cur_base;
    logic [14:0] cur_stride;

    // Shadow copy of the edge walker.
    logic signed [31:0] edge_l;
    logic signed [31:0] edge_r;
    logic signed [31:0] slope_l;
    logic signed [31:0] slope_r;
    logic [11:0]        row_now;
    logic [31:0]        row_addr;

    tsr_pkg::out_item_t span_queue[$];

    // Walk one trapezoid and queue every span that it should produce.
    function automatic void predict_trapezoid(tsr_pkg::in_item_t trap);
        int                 row_count;
        int                 span_count;
        int                 clip_right;
        int                 px_left;
        int                 px_right;
        int                 first_px;
        longint             dx;
        logic signed [31:0] swap_tmp;
        logic               cut;
        tsr_pkg::out_item_t span;

        clip_right = ((cur_width > tsr_pkg::MAX_CLIP_WIDTH) ? 4096 : int'(cur_width)) - 1;
        row_count  = int'(trap.bottom_row) - int'(trap.top_row) + 1;
        row_now    = trap.top_row;
        row_addr   = cur_base + 32'(trap.top_row) * 32'(cur_stride);
        edge_l     = trap.top_left_x;
        edge_r     = trap.top_right_x;

        span.span_color = trap.fill_color & tsr_pkg::COLOR_MASK;

        // An inverted trapezoid gives a single hidden span on its top row.
        if (row_count <= 0) begin
            slope_l              = '0;
            slope_r              = '0;
            span.span_row        = trap.top_row;
            span.span_start      = '0;
            span.span_end        = '0;
            span.span_address    = row_addr;
            span.span_drawn      = 1'b0;
            span.span_last       = 1'b1;
            span.rows_truncated  = 1'b0;
            span_queue.push_back(span);
            return;
        end

        // Slopes use the exact edge difference and the full row count.
        dx      = longint'($signed(trap.bottom_left_x)) - longint'($signed(trap.top_left_x));
        slope_l = 32'(dx / longint'(row_count));
        dx      = longint'($signed(trap.bottom_right_x)) - longint'($signed(trap.top_right_x));
        slope_r = 32'(dx / longint'(row_count));

        cut        = row_count > int'(tsr_pkg::MAX_ROWS);
        span_count = cut ? int'(tsr_pkg::MAX_ROWS) : row_count;

        for (int k = 0; k < span_count; k++) begin
            // Crossed edges trade places together with their slopes.
            if (edge_l > edge_r) begin
                swap_tmp = edge_l;
                edge_l   = edge_r;
                edge_r   = swap_tmp;
                swap_tmp = slope_l;
                slope_l  = slope_r;
                slope_r  = swap_tmp;
            end
            px_left  = int'(edge_l >>> 16);
            px_right = int'(edge_r >>> 16);

            span.span_row       = row_now;
            span.span_start     = '0;
            span.span_end       = '0;
            span.span_address   = row_addr;
            span.span_drawn     = (clip_right >= 0) && (px_right >= 0) && (px_left <= clip_right);
            span.span_last      = (k == span_count - 1);
            span.rows_truncated = cut;
            if (span.span_drawn) begin
                first_px          = (px_left < 0) ? 0 : px_left;
                span.span_start   = 12'(first_px);
                span.span_end     = 12'((px_right > clip_right) ? clip_right : px_right);
                span.span_address = row_addr
                                  + ((32'(first_px) * tsr_pkg::BITS_PER_PIXEL) >> 3);
            end
            span_queue.push_back(span);

            row_addr = row_addr + 32'(cur_stride);
            row_now  = row_now + 12'd1;
            edge_l   = edge_l + slope_l;
            edge_r   = edge_r + slope_r;
        end
    endfunction

    // Count a wrong span and show the first few in full.
    task automatic report_span(tsr_pkg::out_item_t want, tsr_pkg::out_item_t got);
        fail_count++;
        if (fail_count <= 10)
            $display({"span mismatch (expected/actual): row %0d/%0d start %0d/%0d ",
                      "end %0d/%0d addr %h/%h colour %h/%h drawn %b/%b last %b/%b ",
                      "truncated %b/%b"},
                     want.span_row, got.span_row, want.span_start, got.span_start,
                     want.span_end, got.span_end, want.span_address, got.span_address,
                     want.span_color, got.span_color, want.span_drawn, got.span_drawn,
                     want.span_last, got.span_last, want.rows_truncated, got.rows_truncated);
    endtask

    // Sample the register port and both channels at every rising edge.
    always @(posedge aclk) begin : watch_channels
        tsr_pkg::out_item_t want;

        if (!aresetn) begin
            cur_width  = tsr_pkg::SCREEN_WIDTH_RST;
            cur_base   = tsr_pkg::FRAME_BASE_RST;
            cur_stride = tsr_pkg::LINE_STRIDE_RST;
            edge_l     = '0;
            edge_r     = '0;
            slope_l    = '0;
            slope_r    = '0;
            row_now    = '0;
            row_addr   = '0;
            span_queue.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    tsr_pkg::REG_SCREEN_WIDTH: cur_width  = cfg_wdata[12:0];
                    tsr_pkg::REG_FRAME_BASE:   cur_base   = cfg_wdata;
                    tsr_pkg::REG_LINE_STRIDE:  cur_stride = cfg_wdata[14:0];
                    default: ;
                endcase
            end

            // Each returned span must match the oldest one still awaited.
            if (m_valid && m_ready) begin
                if (span_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected span: row %0d start %0d end %0d addr %h",
                                 m_item.span_row, m_item.span_start, m_item.span_end,
                                 m_item.span_address);
                end else begin
                    want = span_queue.pop_front();
                    if ((m_item.span_row       !== want.span_row)       ||
                        (m_item.span_start     !== want.span_start)     ||
                        (m_item.span_end       !== want.span_end)       ||
                        (m_item.span_address   !== want.span_address)   ||
                        (m_item.span_color     !== want.span_color)     ||
                        (m_item.span_drawn     !== want.span_drawn)     ||
                        (m_item.span_last      !== want.span_last)      ||
                        (m_item.rows_truncated !== want.rows_truncated))
                        report_span(want, m_item);
                end
            end

            if (s_valid && s_ready)
                predict_trapezoid(s_item);
        end
        spans_pending = span_queue.size();
    end

endmodule

`default_nettype wire

[dv/trapezoid_span_rasterizer_tb.sv]
// Testbench top of the trapezoid span rasteriser: clock, reset, register writes,
// trapezoid stimulus and span back-pressure, with tsr_span_checker beside the block.
// Depends on tsr_pkg, trapezoid_span_rasterizer and tsr_span_checker.
`default_nettype none

module trapezoid_span_rasterizer_tb;

    // Longest quiet stretch of a correct run is the receiver hold-off plus
    // one full slope division; the limit is many times that.
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_wr_en;
    logic [tsr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [31:0]                   cfg_wdata;
    logic                          s_valid;
    logic                          s_ready;
    tsr_pkg::in_item_t             s_item;
    logic                          m_valid;
    logic                          m_ready;
    tsr_pkg::out_item_t            m_item;

    int fail_count;
    int spans_pending;
    int scr_w     = 320;
    bit quiet     = 1'b0;
    bit hold_req  = 1'b0;

    trapezoid_span_rasterizer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    tsr_span_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_item        (m_item),
        .fail_count    (fail_count),
        .spans_pending (spans_pending)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Span receiver: random stalls, a quiet mode, and one long hold-off on request.
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (quiet) begin
                m_ready = 1'b1;
            end else begin
                m_ready = ($urandom_range(0, 99) >= 15);
            end
        end
    end

    // Watchdog: too long without any item moving ends the run.
    initial begin
        int idle_run;
        idle_run = 0;
        while (idle_run < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("tb: failure");
        $finish;
    end

    // A whole pixel position in 16.16 form.
    function automatic logic [31:0] fx16(int px);
        return 32'(px <<< 16);
    endfunction

    function automatic tsr_pkg::in_item_t trap_of(int top, int bot, logic [31:0] tl,
                                                  logic [31:0] tr, logic [31:0] bl,
                                                  logic [31:0] br, logic [31:0] colour);
        tsr_pkg::in_item_t trap;
        trap.top_row        = 12'(top);
        trap.bottom_row     = 12'(bot);
        trap.top_left_x     = tl;
        trap.top_right_x    = tr;
        trap.bottom_left_x  = bl;
        trap.bottom_right_x = br;
        trap.fill_color     = colour;
        return trap;
    endfunction

    // Edge x near the visible screen most of the time, anywhere otherwise.
    function automatic logic [31:0] rand_edge();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return fx16(int'($urandom_range(0, scr_w + 80)) - 40) | 32'($urandom_range(0, 16'hFFFF));
    endfunction

    // Mostly short trapezoids, some around the row limit, some inverted or wild.
    function automatic tsr_pkg::in_item_t random_trapezoid();
        int sel;
        int rows;
        int top;
        int bot;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            rows = (sel < 55) ? $urandom_range(1, 8) : $urandom_range(60, 70);
            top  = $urandom_range(0, 4096 - rows);
            bot  = top + rows - 1;
        end else if (sel < 80) begin
            top = $urandom_range(1, 4095);
            bot = $urandom_range(0, top - 1);
        end else begin
            top = $urandom_range(0, 4095);
            bot = $urandom_range(0, 4095);
        end
        return trap_of(top, bot, rand_edge(), rand_edge(), rand_edge(), rand_edge(), $urandom);
    endfunction

    // Offer one trapezoid and hold it until the block takes it.
    task automatic offer_trapezoid(tsr_pkg::in_item_t trap);
        @(negedge aclk);
        while (!quiet && $urandom_range(0, 99) < 15) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_item  = trap;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop offering and wait until every awaited span has come back.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (spans_pending != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [tsr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = data;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic set_screen(logic [12:0] width, logic [31:0] base, logic [14:0] stride);
        write_reg(tsr_pkg::REG_SCREEN_WIDTH, 32'(width));
        write_reg(tsr_pkg::REG_FRAME_BASE, base);
        write_reg(tsr_pkg::REG_LINE_STRIDE, 32'(stride));
        scr_w = int'(width);
    endtask

    task automatic run_random(int count);
        repeat (count) offer_trapezoid(random_trapezoid());
        wait_idle();
    endtask

    // Main sequence: reset, directed trapezoids, then random ones over several screens.
    initial begin
        aresetn   = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_item    = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part on an ordinary screen.
        set_screen(13'd320, 32'h1000_0000, 15'd640);
        // Single full-width row, then a single row at the extremes of x.
        offer_trapezoid(trap_of(0, 0, 0, fx16(319), 0, fx16(319), 32'hFFFF_FFFF));
        offer_trapezoid(trap_of(4095, 4095, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000));
        // Inverted trapezoids.
        offer_trapezoid(trap_of(10, 9, fx16(5), fx16(50), fx16(6), fx16(60), 32'h1234_5678));
        offer_trapezoid(trap_of(4095, 0, fx16(-5), fx16(500), 0, 0, 32'hA5A5_5A5A));
        // Exactly the row limit with edges that cross halfway down.
        offer_trapezoid(trap_of(0, 63, 0, fx16(300), fx16(300), 0, 32'h0000_BEEF));
        // One row past the limit, then every row of the screen.
        offer_trapezoid(trap_of(100, 164, fx16(-10), fx16(330), fx16(20), fx16(200),
                                32'h5555_AAAA));
        offer_trapezoid(trap_of(0, 4095, 32'hFFFF_FFFF, fx16(1), 32'h8000_0000,
                                32'h7FFF_FFFF, 32'hFFFF_0001));
        // Hidden spans left of and right of the screen.
        offer_trapezoid(trap_of(20, 23, fx16(-5), 32'hFFFF_FFFF, fx16(-100), fx16(-1),
                                32'h0000_0F0F));
        offer_trapezoid(trap_of(30, 33, fx16(320), fx16(400), fx16(500), fx16(600),
                                32'h0000_F0F0));
        // Clipped on both sides, then a single pixel on the right clip.
        offer_trapezoid(trap_of(40, 45, fx16(-100), fx16(1000), fx16(-50), fx16(2000),
                                32'hDEAD_BEEF));
        offer_trapezoid(trap_of(50, 50, fx16(319), fx16(319) | 32'h0000_FFFF, fx16(319),
                                fx16(319), 32'h0000_0001));
        // Fractional edges either side of zero.
        offer_trapezoid(trap_of(60, 62, 32'hFFFF_8000, 32'h0000_8000, 32'hFFFE_4000,
                                32'h0001_C000, 32'h8000_0000));
        // Edge differences that overflow 32 bits.
        offer_trapezoid(trap_of(70, 71, 32'h7FFF_0000, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_0000, 32'h0F0F_0F0F));
        offer_trapezoid(trap_of(72, 72, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'hF0F0_F0F0));
        // Negative slopes that truncate toward zero.
        offer_trapezoid(trap_of(80, 82, 0, fx16(10), 32'hFFFF_FFF9, 32'd7, 32'h0000_7777));
        // Bottom rows of the row range, then edges crossed from the start.
        offer_trapezoid(trap_of(4090, 4095, fx16(3), fx16(310), fx16(-3), fx16(330),
                                32'h3333_3333));
        offer_trapezoid(trap_of(90, 95, fx16(200), fx16(100), fx16(50), fx16(250),
                                32'hCCCC_CCCC));
        offer_trapezoid(trap_of(0, 1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                                32'h7FFF_FFFF, 32'h0000_FFFF));
        wait_idle();

        // Narrowest screen with an address that wraps.
        set_screen(13'd1, 32'hFFFF_FFF0, 15'd1);
        run_random(19);

        // Widest clipped screen with a stride of 16384.
        set_screen(13'd4096, 32'hFFFF_FFFF, 15'd16384);
        run_random(19);

        // Zero width hides every span; the receiver holds off for a long stretch.
        set_screen(13'd0, 32'h0000_0000, 15'd32767);
        hold_req = 1'b1;
        run_random(19);

        // Width above the clip limit and a zero stride.
        set_screen(13'd8191, $urandom, 15'd0);
        run_random(19);

        // Ordinary screen with no idling on either side.
        quiet = 1'b1;
        set_screen(13'd640, 32'h0000_0000, 15'd320);
        run_random(19);
        quiet = 1'b0;

        // Random screen geometry.
        set_screen(13'($urandom_range(1, 4096)), $urandom, 15'($urandom_range(1, 16384)));
        run_random(19);

        repeat (40) @(negedge aclk);
        if (fail_count == 0 && spans_pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
